// File: design/trp_pkg.sv
`default_nettype none

package trp_pkg;

    // Field widths fixed by the stream format
    localparam int NET_W = 10;
    localparam int COL_W = 8;

    // Defaults for the top-level parameters
    localparam int DEF_NET_ID_BITS = 10;
    localparam int DEF_COLUMN_BITS = 8;

    // Slave-side tdata layout: six net IDs, lowest field first, padded to 64 bits
    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 3;
    localparam int OFS_P_SOURCE = 0;
    localparam int OFS_P_DRAIN  = OFS_P_SOURCE + NET_W;
    localparam int OFS_P_GATE   = OFS_P_DRAIN + NET_W;
    localparam int OFS_N_SOURCE = OFS_P_GATE + NET_W;
    localparam int OFS_N_DRAIN  = OFS_N_SOURCE + NET_W;
    localparam int OFS_N_GATE   = OFS_N_DRAIN + NET_W;

    // Slave-side tuser bits
    localparam int USR_START_CELL = 0;
    localparam int USR_P_VALID    = 1;
    localparam int USR_N_VALID    = 2;

    // Master-side layout: three columns in tdata, overflow flag in tuser
    localparam int M_TDATA_W = 3 * COL_W;
    localparam int M_TUSER_W = 1;
    localparam int OFS_P_COLUMN = 0;
    localparam int OFS_N_COLUMN = OFS_P_COLUMN + COL_W;
    localparam int OFS_WIDTH    = OFS_N_COLUMN + COL_W;
    localparam int USR_OVERFLOW = 0;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // One classified transaction as it waits in the queue
    typedef struct packed {
        logic             start_cell;
        logic             p_valid;
        logic             n_valid;
        logic             pair;
        logic [NET_W-1:0] p_source;
        logic [NET_W-1:0] p_drain;
        logic [NET_W-1:0] p_gate;
        logic [NET_W-1:0] n_source;
        logic [NET_W-1:0] n_drain;
        logic [NET_W-1:0] n_gate;
    } t_item;

    // One placement result
    typedef struct packed {
        logic [COL_W-1:0] p_column;
        logic [COL_W-1:0] n_column;
        logic [COL_W-1:0] width_so_far;
        logic             overflow;
    } t_result;

endpackage

`default_nettype wire

// File: design/transistor_row_placer_unit.sv
`default_nettype none

// Channel   Dir  Signals                         Payload
// s_axis    in   tvalid/tready/tdata/tuser       one device pair or single-row device
// m_axis    out  tvalid/tready/tdata/tuser       columns, width so far, overflow
//
// One transaction per cycle sustained in both directions while m_axis tready stays high.
// An accepted input transaction passes through the front register, the two-entry queue,
// then the placement stage with its output register, to become a result.
// Reset clears all placement state and empties every stage.
// The front keeps accepting while a result waits on m_axis, until the queue and the front register are both full.

module transistor_row_placer_unit
    import trp_pkg::*;
#(
    parameter int NET_ID_BITS = DEF_NET_ID_BITS,
    parameter int COLUMN_BITS = DEF_COLUMN_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // p_source, p_drain, p_gate, n_source, n_drain, n_gate, zero pad
    input  wire logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // start_cell, p_valid, n_valid
    input  wire logic [S_TUSER_W-1:0] i_s_axis_tuser,
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    // p_column, n_column, width_so_far
    output logic [M_TDATA_W-1:0]      o_m_axis_tdata,
    // overflow
    output logic [M_TUSER_W-1:0]      o_m_axis_tuser
);

    logic    fr_vld;
    logic    q_rdy;
    t_item   fr_item;
    logic    q_vld;
    logic    bk_rdy;
    t_item   q_item;
    t_result bk_result;

    trp_front #(
        .NET_ID_BITS(NET_ID_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_vld           (fr_vld),
        .i_rdy           (q_rdy),
        .o_item          (fr_item)
    );

    trp_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_vld  (fr_vld),
        .o_wr_rdy  (q_rdy),
        .i_wr_item (fr_item),
        .o_rd_vld  (q_vld),
        .i_rd_rdy  (bk_rdy),
        .o_rd_item (q_item)
    );

    trp_back #(
        .COLUMN_BITS(COLUMN_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (q_vld),
        .o_rdy    (bk_rdy),
        .i_item   (q_item),
        .o_vld    (o_m_axis_tvalid),
        .i_rdy    (i_m_axis_tready),
        .o_result (bk_result)
    );

    // Pack the result
    assign o_m_axis_tdata[OFS_P_COLUMN +: COL_W] = bk_result.p_column;
    assign o_m_axis_tdata[OFS_N_COLUMN +: COL_W] = bk_result.n_column;
    assign o_m_axis_tdata[OFS_WIDTH +: COL_W]    = bk_result.width_so_far;
    assign o_m_axis_tuser[USR_OVERFLOW]          = bk_result.overflow;

    // A front entry blocked by a full queue is neither lost nor altered
    a_front_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fr_vld && !q_rdy |=> fr_vld && $stable(fr_item))
        else $error("front entry changed while queue was full");

    // A queued entry stays available while the back stage is stalled
    a_queue_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_vld && !bk_rdy |=> q_vld && $stable(q_item))
        else $error("queue head changed while back stage stalled");

    // The back stage only stalls when a result is waiting on the master side
    a_back_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !bk_rdy |-> o_m_axis_tvalid && !i_m_axis_tready)
        else $error("back stage stalled without output backpressure");

    // Reset empties the output
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire

// File: design/trp_front.sv
`default_nettype none

module trp_front
    import trp_pkg::*;
#(
    parameter int NET_ID_BITS = DEF_NET_ID_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] i_s_axis_tdata,
    input  wire logic [S_TUSER_W-1:0] i_s_axis_tuser,
    output logic                      o_vld,
    input  wire logic                 i_rdy,
    output t_item                     o_item
);

    // Only the low bits of a net ID take part in compares
    localparam int NCMP = (NET_ID_BITS < NET_W) ? NET_ID_BITS : NET_W;

    logic  r_vld;
    t_item r_item;
    t_item n_item;
    logic  w_accept;

    function automatic logic [NET_W-1:0] net_mask(input logic [NET_W-1:0] x);
        return NET_W'(x[NCMP-1:0]);
    endfunction

    // Unpack and classify the incoming transaction
    always_comb begin
        n_item.start_cell = i_s_axis_tuser[USR_START_CELL];
        n_item.p_valid    = i_s_axis_tuser[USR_P_VALID];
        n_item.n_valid    = i_s_axis_tuser[USR_N_VALID];
        n_item.pair       = i_s_axis_tuser[USR_P_VALID] & i_s_axis_tuser[USR_N_VALID];
        n_item.p_source   = net_mask(i_s_axis_tdata[OFS_P_SOURCE +: NET_W]);
        n_item.p_drain    = net_mask(i_s_axis_tdata[OFS_P_DRAIN +: NET_W]);
        n_item.p_gate     = net_mask(i_s_axis_tdata[OFS_P_GATE +: NET_W]);
        n_item.n_source   = net_mask(i_s_axis_tdata[OFS_N_SOURCE +: NET_W]);
        n_item.n_drain    = net_mask(i_s_axis_tdata[OFS_N_DRAIN +: NET_W]);
        n_item.n_gate     = net_mask(i_s_axis_tdata[OFS_N_GATE +: NET_W]);
    end

    assign o_s_axis_tready = !r_vld || i_rdy;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // Hold the classified transaction until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_accept) begin
            r_vld <= 1'b1;
        end else if (i_rdy) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= n_item;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule

`default_nettype wire

// File: design/trp_queue.sv
`default_nettype none

module trp_queue
    import trp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_wr_vld,
    output logic       o_wr_rdy,
    input  wire t_item i_wr_item,
    output logic       o_rd_vld,
    input  wire logic  i_rd_rdy,
    output t_item      o_rd_item
);

    t_item            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_wr_rdy  = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_rd_vld  = (r_count != '0);
    assign o_rd_item = r_mem[r_rd_ptr];
    assign w_push    = i_wr_vld && o_wr_rdy;
    assign w_pop     = o_rd_vld && i_rd_rdy;

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (w_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // Store the entry
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_wr_item;
        end
    end

endmodule

`default_nettype wire

// File: design/trp_back.sv
`default_nettype none

module trp_back
    import trp_pkg::*;
#(
    parameter int COLUMN_BITS = DEF_COLUMN_BITS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_vld,
    output logic       o_rdy,
    input  wire t_item i_item,
    output logic       o_vld,
    input  wire logic  i_rdy,
    output t_result    o_result
);

    localparam int CW  = COLUMN_BITS;
    localparam int EXT = (CW > COL_W) ? CW : COL_W;
    localparam logic [CW-1:0] COL_MAX = {CW{1'b1}};

    // Placement state
    logic [CW-1:0]    r_nxp, r_nxn;
    logic [NET_W-1:0] r_prn, r_nrn;
    logic [CW-1:0]    r_ppc, r_pnc;
    logic [NET_W-1:0] r_ppg, r_png;
    logic             r_hp, r_hn;
    logic [CW-1:0]    r_max;
    logic             r_ovf;

    // State after an optional start-of-cell clear
    logic [CW-1:0]    e_nxp, e_nxn;
    logic [NET_W-1:0] e_prn, e_nrn;
    logic [CW-1:0]    e_ppc, e_pnc;
    logic [NET_W-1:0] e_ppg, e_png;
    logic             e_hp, e_hn;
    logic [CW-1:0]    e_max;
    logic             e_ovf;

    // Next state
    logic [CW-1:0]    n_nxp, n_nxn;
    logic [NET_W-1:0] n_prn, n_nrn;
    logic [CW-1:0]    n_ppc, n_pnc;
    logic [NET_W-1:0] n_ppg, n_png;
    logic             n_hp, n_hn;
    logic [CW-1:0]    n_max;
    logic             n_ovf;

    logic             p_skip, n_skip1, n_skip2;
    logic [CW-1:0]    p_x, p_next, n_x1, n_x, n_next, m1;
    logic             o1, o2, o3, o4, o5;
    logic [CW-1:0]    w_pcol, w_ncol;

    logic             r_out_vld;
    t_result          r_out;
    t_result          n_out;
    logic             w_take;

    // Saturating increment: {saturated, value}
    function automatic logic [CW:0] bump(input logic [CW-1:0] x);
        if (x == COL_MAX) begin
            return {1'b1, COL_MAX};
        end
        return {1'b0, x + CW'(1)};
    endfunction

    function automatic logic [COL_W-1:0] to_out(input logic [CW-1:0] x);
        logic [EXT-1:0] w;
        w = EXT'(x);
        return w[COL_W-1:0];
    endfunction

    // Clear the running state on the first transaction of a cell
    always_comb begin
        if (i_item.start_cell) begin
            e_nxp = CW'(1);
            e_nxn = CW'(1);
            e_prn = '0;
            e_nrn = '0;
            e_ppc = '0;
            e_pnc = '0;
            e_ppg = '0;
            e_png = '0;
            e_hp  = 1'b0;
            e_hn  = 1'b0;
            e_max = '0;
            e_ovf = 1'b0;
        end else begin
            e_nxp = r_nxp;
            e_nxn = r_nxn;
            e_prn = r_prn;
            e_nrn = r_nrn;
            e_ppc = r_ppc;
            e_pnc = r_pnc;
            e_ppg = r_ppg;
            e_png = r_png;
            e_hp  = r_hp;
            e_hn  = r_hn;
            e_max = r_max;
            e_ovf = r_ovf;
        end
    end

    // Place the PMOS device, then the NMOS device
    always_comb begin
        p_skip = e_hp && ((i_item.p_source != e_prn) ||
                 (i_item.pair && e_hn && (e_nxp == e_pnc) && (e_png != i_item.p_gate)));
        if (p_skip) begin
            {o1, p_x} = bump(e_nxp);
        end else begin
            {o1, p_x} = {1'b0, e_nxp};
        end
        {o2, p_next} = bump(p_x);

        n_skip1 = e_hn && ((i_item.n_source != e_nrn) ||
                  (i_item.pair && e_hp && (e_nxn == e_ppc) && (e_ppg != i_item.n_gate)));
        if (n_skip1) begin
            {o3, n_x1} = bump(e_nxn);
        end else begin
            {o3, n_x1} = {1'b0, e_nxn};
        end
        n_skip2 = i_item.pair && (n_x1 == p_x) && (i_item.p_gate != i_item.n_gate);
        if (n_skip2) begin
            {o4, n_x} = bump(n_x1);
        end else begin
            {o4, n_x} = {1'b0, n_x1};
        end
        {o5, n_next} = bump(n_x);

        w_pcol = i_item.p_valid ? p_x : '0;
        w_ncol = i_item.n_valid ? n_x : '0;

        m1    = (i_item.p_valid && (p_x > e_max)) ? p_x : e_max;
        n_max = (i_item.n_valid && (n_x > m1)) ? n_x : m1;
        n_ovf = e_ovf || (i_item.p_valid && (o1 || o2)) ||
                (i_item.n_valid && (o3 || o4 || o5));
    end

    // Update per-row history
    always_comb begin
        n_nxp = e_nxp;
        n_prn = e_prn;
        n_ppc = e_ppc;
        n_ppg = e_ppg;
        n_hp  = e_hp;
        n_nxn = e_nxn;
        n_nrn = e_nrn;
        n_pnc = e_pnc;
        n_png = e_png;
        n_hn  = e_hn;
        if (i_item.p_valid) begin
            n_nxp = p_next;
            n_prn = i_item.p_drain;
            n_ppc = p_x;
            n_ppg = i_item.p_gate;
            n_hp  = 1'b1;
        end
        if (i_item.n_valid) begin
            n_nxn = n_next;
            n_nrn = i_item.n_drain;
            n_pnc = n_x;
            n_png = i_item.n_gate;
            n_hn  = 1'b1;
        end
        n_out.p_column     = to_out(w_pcol);
        n_out.n_column     = to_out(w_ncol);
        n_out.width_so_far = to_out(n_max);
        n_out.overflow     = n_ovf;
    end

    assign o_rdy  = !r_out_vld || i_rdy;
    assign w_take = i_vld && o_rdy;

    // Commit state on each consumed transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nxp <= CW'(1);
            r_nxn <= CW'(1);
            r_prn <= '0;
            r_nrn <= '0;
            r_ppc <= '0;
            r_pnc <= '0;
            r_ppg <= '0;
            r_png <= '0;
            r_hp  <= 1'b0;
            r_hn  <= 1'b0;
            r_max <= '0;
            r_ovf <= 1'b0;
        end else if (w_take) begin
            r_nxp <= n_nxp;
            r_nxn <= n_nxn;
            r_prn <= n_prn;
            r_nrn <= n_nrn;
            r_ppc <= n_ppc;
            r_pnc <= n_pnc;
            r_ppg <= n_ppg;
            r_png <= n_png;
            r_hp  <= n_hp;
            r_hn  <= n_hn;
            r_max <= n_max;
            r_ovf <= n_ovf;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_take) begin
            r_out_vld <= 1'b1;
        end else if (i_rdy) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= n_out;
        end
    end

    assign o_vld    = r_out_vld;
    assign o_result = r_out;

endmodule

`default_nettype wire

// File: dv/transistor_row_placer_unit_tb.sv
`timescale 1ns / 1ps

module transistor_row_placer_unit_tb;
    import trp_pkg::*;

    localparam logic [COL_W-1:0] COL_TOP = {COL_W{1'b1}};
    localparam int DRAIN_CYCLES   = 12;
    localparam int RANDOM_ITEMS   = 560;
    localparam int SAT_PAIR_ITEMS = 140;
    localparam int SAT_ROW_ITEMS  = 135;

    typedef enum int {
        IDLE_NONE,
        IDLE_LIGHT,
        IDLE_HEAVY
    } t_idle_mode;

    // One device pair or single-row device as it enters the block
    typedef struct packed {
        logic             start_cell;
        logic             p_valid;
        logic             n_valid;
        logic [NET_W-1:0] p_source;
        logic [NET_W-1:0] p_drain;
        logic [NET_W-1:0] p_gate;
        logic [NET_W-1:0] n_source;
        logic [NET_W-1:0] n_drain;
        logic [NET_W-1:0] n_gate;
    } t_dev_item;

    // Placement state of both rows within the current cell
    typedef struct {
        logic [COL_W-1:0] next_p_col;
        logic [COL_W-1:0] next_n_col;
        logic [NET_W-1:0] p_right_net;
        logic [NET_W-1:0] n_right_net;
        logic [COL_W-1:0] prev_p_col;
        logic [COL_W-1:0] prev_n_col;
        logic [NET_W-1:0] prev_p_gate;
        logic [NET_W-1:0] prev_n_gate;
        logic             have_p;
        logic             have_n;
        logic [COL_W-1:0] max_col;
        logic             overflow_seen;
    } t_row_state;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] i_s_axis_tdata = '0;
    logic [S_TUSER_W-1:0] i_s_axis_tuser = '0;
    logic                 i_m_axis_tready = 1'b0;
    logic                 o_s_axis_tready;
    logic                 o_m_axis_tvalid;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;
    logic [M_TUSER_W-1:0] o_m_axis_tuser;

    t_row_state rows;
    t_result    pending_placements[$];
    t_result    want_place;
    t_idle_mode sender_idle = IDLE_NONE;
    t_idle_mode receiver_idle = IDLE_NONE;
    int         burst_left = 1;
    int         ready_run = 0;
    int         error_count = 0;
    int         items_placed = 0;
    int         cells_started = 0;
    int         placements_checked = 0;
    int         overflow_results = 0;

    transistor_row_placer_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_row_state cleared_rows();
        t_row_state st;
        st.next_p_col    = COL_W'(1);
        st.next_n_col    = COL_W'(1);
        st.p_right_net   = '0;
        st.n_right_net   = '0;
        st.prev_p_col    = '0;
        st.prev_n_col    = '0;
        st.prev_p_gate   = '0;
        st.prev_n_gate   = '0;
        st.have_p        = 1'b0;
        st.have_n        = 1'b0;
        st.max_col       = '0;
        st.overflow_seen = 1'b0;
        return st;
    endfunction

    // Advance a column, holding at the top value and flagging the attempt
    function automatic logic [COL_W-1:0] step_col(input logic [COL_W-1:0] c);
        if (c == COL_TOP) begin
            rows.overflow_seen = 1'b1;
            return COL_TOP;
        end
        return c + 1'b1;
    endfunction

    // Place one accepted transaction and return the result it must produce
    function automatic t_result place_devices(input t_dev_item it);
        t_row_state       old;
        logic [COL_W-1:0] pcol;
        logic [COL_W-1:0] ncol;
        logic [COL_W-1:0] xp;
        logic [COL_W-1:0] xn;
        t_result          r;
        if (it.start_cell) begin
            rows = cleared_rows();
        end
        old  = rows;
        pcol = '0;
        ncol = '0;
        xp   = old.next_p_col;
        xn   = old.next_n_col;
        if (it.p_valid && it.n_valid) begin
            // PMOS: diffusion break, else gate clash with the last NMOS device
            if (old.have_p) begin
                if (it.p_source != old.p_right_net) begin
                    xp = step_col(xp);
                end else if (old.have_n && xp == old.prev_n_col
                             && old.prev_n_gate != it.p_gate) begin
                    xp = step_col(xp);
                end
            end
            pcol = xp;
            rows.next_p_col = step_col(xp);
            // NMOS: diffusion break, else clash with the last PMOS device
            if (old.have_n) begin
                if (it.n_source != old.n_right_net) begin
                    xn = step_col(xn);
                end else if (old.have_p && xn == old.prev_p_col
                             && old.prev_p_gate != it.n_gate) begin
                    xn = step_col(xn);
                end
            end
            // then clash with the PMOS device of this same pair
            if (xn == pcol && it.p_gate != it.n_gate) begin
                xn = step_col(xn);
            end
            ncol = xn;
            rows.next_n_col = step_col(xn);
        end else if (it.p_valid) begin
            if (old.have_p && it.p_source != old.p_right_net) begin
                xp = step_col(xp);
            end
            pcol = xp;
            rows.next_p_col = step_col(xp);
        end else if (it.n_valid) begin
            if (old.have_n && it.n_source != old.n_right_net) begin
                xn = step_col(xn);
            end
            ncol = xn;
            rows.next_n_col = step_col(xn);
        end
        // Record the placed devices as the new right edge of each row
        if (it.p_valid) begin
            rows.p_right_net = it.p_drain;
            rows.prev_p_col  = pcol;
            rows.prev_p_gate = it.p_gate;
            rows.have_p      = 1'b1;
            if (pcol > rows.max_col) begin
                rows.max_col = pcol;
            end
        end
        if (it.n_valid) begin
            rows.n_right_net = it.n_drain;
            rows.prev_n_col  = ncol;
            rows.prev_n_gate = it.n_gate;
            rows.have_n      = 1'b1;
            if (ncol > rows.max_col) begin
                rows.max_col = ncol;
            end
        end
        r.p_column     = pcol;
        r.n_column     = ncol;
        r.width_so_far = rows.max_col;
        r.overflow     = rows.overflow_seen;
        return r;
    endfunction

    function automatic t_dev_item dev(
        input logic             sc,
        input logic             pv,
        input logic             nv,
        input logic [NET_W-1:0] ps,
        input logic [NET_W-1:0] pd,
        input logic [NET_W-1:0] pg,
        input logic [NET_W-1:0] ns,
        input logic [NET_W-1:0] nd,
        input logic [NET_W-1:0] ng
    );
        t_dev_item it;
        it.start_cell = sc;
        it.p_valid    = pv;
        it.n_valid    = nv;
        it.p_source   = ps;
        it.p_drain    = pd;
        it.p_gate     = pg;
        it.n_source   = ns;
        it.n_drain    = nd;
        it.n_gate     = ng;
        return it;
    endfunction

    // Mostly a small pool of nets so that sharing and gate matches happen often
    function automatic logic [NET_W-1:0] rand_net();
        if ($urandom_range(0, 3) != 0) begin
            return NET_W'($urandom_range(0, 7));
        end
        return NET_W'($urandom_range(0, (1 << NET_W) - 1));
    endfunction

    // Present one transaction, wait for acceptance, then maybe close the burst
    task automatic send_item(input t_dev_item it);
        logic [S_TDATA_W-1:0] data;
        logic [S_TUSER_W-1:0] user;
        data = '0;
        data[OFS_P_SOURCE +: NET_W] = it.p_source;
        data[OFS_P_DRAIN +: NET_W]  = it.p_drain;
        data[OFS_P_GATE +: NET_W]   = it.p_gate;
        data[OFS_N_SOURCE +: NET_W] = it.n_source;
        data[OFS_N_DRAIN +: NET_W]  = it.n_drain;
        data[OFS_N_GATE +: NET_W]   = it.n_gate;
        user = '0;
        user[USR_START_CELL] = it.start_cell;
        user[USR_P_VALID]    = it.p_valid;
        user[USR_N_VALID]    = it.n_valid;
        i_s_axis_tdata  <= data;
        i_s_axis_tuser  <= user;
        i_s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_axis_tready) begin
            @(posedge i_clk);
        end
        pending_placements.push_back(place_devices(it));
        items_placed++;
        if (it.start_cell) begin
            cells_started++;
        end
        if (sender_idle != IDLE_NONE) begin
            burst_left--;
            if (burst_left <= 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat ((sender_idle == IDLE_LIGHT) ? $urandom_range(1, 2)
                                                    : $urandom_range(1, 8)) begin
                    @(posedge i_clk);
                end
                burst_left = $urandom_range(1, 12);
            end
        end
    endtask

    // Sink stalls in runs whose shape depends on the current idle mode
    always @(posedge i_clk) begin
        if (ready_run > 0) begin
            ready_run--;
        end else begin
            case (receiver_idle)
                IDLE_NONE: begin
                    i_m_axis_tready <= 1'b1;
                    ready_run = 8;
                end
                IDLE_LIGHT: begin
                    i_m_axis_tready <= ($urandom_range(0, 3) != 0);
                    ready_run = $urandom_range(0, 3);
                end
                default: begin
                    i_m_axis_tready <= 1'($urandom_range(0, 1));
                    ready_run = $urandom_range(0, 11);
                end
            endcase
        end
    end

    // Compare every result transaction with the oldest pending placement
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_placements.size() == 0) begin
                $error("result with no placement pending: tdata %h tuser %h",
                       o_m_axis_tdata, o_m_axis_tuser);
                error_count++;
            end else begin
                want_place = pending_placements.pop_front();
                placements_checked++;
                if (want_place.overflow) begin
                    overflow_results++;
                end
                if (o_m_axis_tdata[OFS_P_COLUMN +: COL_W] !== want_place.p_column) begin
                    $error("p_column: expected %0d, actual %0d", want_place.p_column,
                           o_m_axis_tdata[OFS_P_COLUMN +: COL_W]);
                    error_count++;
                end
                if (o_m_axis_tdata[OFS_N_COLUMN +: COL_W] !== want_place.n_column) begin
                    $error("n_column: expected %0d, actual %0d", want_place.n_column,
                           o_m_axis_tdata[OFS_N_COLUMN +: COL_W]);
                    error_count++;
                end
                if (o_m_axis_tdata[OFS_WIDTH +: COL_W] !== want_place.width_so_far) begin
                    $error("width_so_far: expected %0d, actual %0d", want_place.width_so_far,
                           o_m_axis_tdata[OFS_WIDTH +: COL_W]);
                    error_count++;
                end
                if (o_m_axis_tuser[USR_OVERFLOW] !== want_place.overflow) begin
                    $error("overflow: expected %0d, actual %0d", want_place.overflow,
                           o_m_axis_tuser[USR_OVERFLOW]);
                    error_count++;
                end
            end
        end
    end

    // Hand-picked pairs and tails: sharing, breaks, gate clashes, empties, extremes
    task automatic test_directed_placement();
        sender_idle   = IDLE_NONE;
        receiver_idle = IDLE_NONE;
        send_item(dev(1, 1, 1, 0, 0, 0, 0, 0, 0));
        send_item(dev(0, 1, 1, 0, 5, 7, 0, 6, 7));
        send_item(dev(0, 1, 1, 5, 9, 3, 6, 2, 4));
        send_item(dev(0, 1, 1, 9, 1, 9, 2, 3, 1));
        send_item(dev(0, 1, 1, 4, 4, 4, 4, 4, 4));
        send_item(dev(0, 1, 0, 4, 8, 4, 0, 0, 0));
        send_item(dev(0, 1, 0, 7, 8, 4, 0, 0, 0));
        send_item(dev(0, 0, 1, 0, 0, 0, 4, 5, 4));
        send_item(dev(0, 0, 1, 0, 0, 0, 9, 5, 4));
        send_item(dev(0, 0, 0, 1023, 1023, 1023, 1023, 1023, 1023));
        sender_idle   = IDLE_LIGHT;
        receiver_idle = IDLE_LIGHT;
        send_item(dev(1, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(dev(0, 0, 1, 1023, 1023, 1023, 1023, 1023, 1023));
        send_item(dev(0, 1, 1, 1023, 1023, 1023, 1023, 1023, 0));
        send_item(dev(0, 1, 1, 10'h2AA, 10'h155, 10'h2AA, 10'h155, 10'h2AA, 10'h155));
        send_item(dev(0, 1, 1, 10'h155, 10'h2AA, 10'h155, 10'h2AA, 10'h155, 10'h2AA));
        send_item(dev(1, 0, 1, 0, 0, 0, 0, 0, 0));
        send_item(dev(0, 1, 0, 3, 3, 3, 0, 0, 0));
        // restart on a PMOS-only device, then an NMOS clash with the last PMOS
        send_item(dev(1, 1, 0, 20, 21, 22, 0, 0, 0));
        send_item(dev(0, 1, 1, 21, 11, 12, 0, 13, 12));
        send_item(dev(0, 1, 1, 99, 2, 5, 13, 1, 6));
        send_item(dev(0, 1, 1, 2, 2, 6, 1, 1, 6));
    endtask

    // Long cells with broken diffusion to drive both rows into saturation
    task automatic test_column_saturation();
        logic [NET_W-1:0] p_tail;
        logic [NET_W-1:0] n_tail;
        t_dev_item        it;
        p_tail        = '0;
        n_tail        = '0;
        sender_idle   = IDLE_NONE;
        receiver_idle = IDLE_HEAVY;
        for (int i = 0; i < SAT_PAIR_ITEMS; i++) begin
            it = dev(i == 0, 1, 1, p_tail ^ 10'h1, rand_net(), rand_net(),
                     n_tail ^ 10'h1, rand_net(), rand_net());
            p_tail = it.p_drain;
            n_tail = it.n_drain;
            send_item(it);
        end
        // saturated tails of either row
        sender_idle = IDLE_HEAVY;
        for (int i = 0; i < 4; i++) begin
            send_item(dev(0, 1, 0, rand_net(), rand_net(), rand_net(), 0, 0, 0));
            send_item(dev(0, 0, 1, 0, 0, 0, rand_net(), rand_net(), rand_net()));
        end
        // a single NMOS row on its own
        receiver_idle = IDLE_NONE;
        for (int i = 0; i < SAT_ROW_ITEMS; i++) begin
            it = dev(i == 0, 0, 1, 0, 0, 0, n_tail ^ 10'h1, rand_net(), rand_net());
            n_tail = it.n_drain;
            send_item(it);
        end
    endtask

    // Cells of pairs followed by the tail of the longer row, with stray items
    task automatic run_random_cell(input int p_len, input int n_len, input int chain_pct);
        t_dev_item        it;
        logic [NET_W-1:0] p_tail;
        logic [NET_W-1:0] n_tail;
        int               len;
        len    = (p_len > n_len) ? p_len : n_len;
        p_tail = rand_net();
        n_tail = rand_net();
        for (int i = 0; i < len; i++) begin
            it.start_cell = (i == 0);
            it.p_valid    = (i < p_len);
            it.n_valid    = (i < n_len);
            it.p_source   = ($urandom_range(1, 100) <= chain_pct) ? p_tail : rand_net();
            it.p_drain    = rand_net();
            it.p_gate     = rand_net();
            it.n_source   = ($urandom_range(1, 100) <= chain_pct) ? n_tail : rand_net();
            it.n_drain    = rand_net();
            it.n_gate     = ($urandom_range(0, 1) != 0) ? it.p_gate : rand_net();
            // stray item: odd valid bits, an early restart, full-range nets
            if ($urandom_range(0, 11) == 0) begin
                it.start_cell = ($urandom_range(0, 4) == 0);
                it.p_valid    = 1'($urandom_range(0, 1));
                it.n_valid    = 1'($urandom_range(0, 1));
                it.p_gate     = NET_W'($urandom_range(0, (1 << NET_W) - 1));
                it.n_source   = NET_W'($urandom_range(0, (1 << NET_W) - 1));
            end
            if (it.p_valid) begin
                p_tail = it.p_drain;
            end
            if (it.n_valid) begin
                n_tail = it.n_drain;
            end
            send_item(it);
        end
    endtask

    task automatic test_random_cells();
        int start_count;
        int p_len;
        int n_len;
        start_count = items_placed;
        while (items_placed - start_count < RANDOM_ITEMS) begin
            sender_idle   = t_idle_mode'($urandom_range(0, 2));
            receiver_idle = t_idle_mode'($urandom_range(0, 2));
            if ($urandom_range(0, 7) == 0) begin
                p_len = $urandom_range(90, 160);
                n_len = $urandom_range(90, 160);
            end else begin
                p_len = $urandom_range(0, 24);
                n_len = $urandom_range(1, 24);
            end
            run_random_cell(p_len, n_len, $urandom_range(50, 95));
        end
    endtask

    initial begin
        rows = cleared_rows();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_placement();
        test_column_saturation();
        test_random_cells();
        i_s_axis_tvalid <= 1'b0;
        // drain outstanding results, then watch for strays
        while (pending_placements.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Placed %0d transactions over %0d cells, checked %0d results.",
                 items_placed, cells_started, placements_checked);
        $display("%0d results carried the overflow flag; %0d mismatches.",
                 overflow_results, error_count);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Hard stop for a hung handshake
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// File: sim.f
design/trp_pkg.sv
design/trp_front.sv
design/trp_queue.sv
design/trp_back.sv
design/transistor_row_placer_unit.sv
dv/transistor_row_placer_unit_tb.sv
